// ===== rtl/dpscm_pkg.sv =====
// ----------------------------------------------------------------------------
// dpscm_pkg
// Shared sizes, codes and types for the direct plus sorted code map.
// ----------------------------------------------------------------------------
package dpscm_pkg;

  localparam int CODE_W     = 21;
  localparam int VALUE_W    = 16;
  localparam int DIRECT_SIZE = 256;
  localparam int DIRECT_AW  = $clog2(DIRECT_SIZE);
  localparam int SORTED_CAP = 1024;
  localparam int SORTED_AW  = $clog2(SORTED_CAP);
  localparam int CNT_W      = $clog2(SORTED_CAP + 1);

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic [CODE_W-1:0]  key;
    logic [VALUE_W-1:0] value;
  } sorted_entry_t;

endpackage

// ===== rtl/direct_plus_sorted_code_map_unit.sv =====
// ----------------------------------------------------------------------------
// direct_plus_sorted_code_map_unit
// Key-to-value map for character codes: direct table plus sorted table.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with done high, and it cannot be held off.
// Codes below the direct size are served from the direct table: an insert
// is written in ST_DIR, a lookup is read out through ST_DRD. Sorted lookups
// run a binary search through the single read port of the sorted memory,
// each probe addressed in ST_BS_ADDR and compared in ST_BS_CMP. A sorted
// insert runs the same search; a present key is overwritten in place, a full
// table drops the insert with table_full, else every entry above the insert
// point moves up by one, each read over that same port.
// busy stays high until the result is shown; a new request can be taken in
// the done cycle.
module direct_plus_sorted_code_map_unit
  import dpscm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic [CODE_W-1:0]  char_code,
  input  logic [VALUE_W-1:0] entry_value,
  output logic               done,
  output logic               found,
  output logic [VALUE_W-1:0] found_value,
  output logic               table_full
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_DIR     = 4'd1;
  localparam logic [3:0] ST_DRD     = 4'd2;
  localparam logic [3:0] ST_BS_ADDR = 4'd3;
  localparam logic [3:0] ST_BS_CMP  = 4'd4;
  localparam logic [3:0] ST_PLACE   = 4'd5;
  localparam logic [3:0] ST_SH_RD   = 4'd6;
  localparam logic [3:0] ST_SH_WR   = 4'd7;

  logic [3:0]           state, state_next;
  logic                 op_r;
  logic [CODE_W-1:0]    code_r;
  logic [VALUE_W-1:0]   value_r;
  logic [CNT_W-1:0]     lo, lo_next, hi, hi_next, mid, mid_next;
  logic [CNT_W-1:0]     count, count_next, j, j_next;
  logic                 done_next, found_next, full_next;
  logic [VALUE_W-1:0]   fval_next;

  logic [DIRECT_SIZE-1:0] direct_valid;
  logic [VALUE_W-1:0]     direct_mem [DIRECT_SIZE];
  logic [VALUE_W-1:0]     direct_rdata;
  logic                   direct_we;

  sorted_entry_t          sorted_mem [SORTED_CAP];
  sorted_entry_t          sorted_rdata, sorted_wdata;
  logic                   sorted_we;
  logic [SORTED_AW-1:0]   sorted_raddr, sorted_waddr;

  logic                   accept;
  logic [DIRECT_AW-1:0]   dir_idx;
  logic                   is_direct;
  logic [CNT_W-1:0]       mid_calc;

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign dir_idx   = code_r[DIRECT_AW-1:0];
  assign is_direct = (code_r < CODE_W'(DIRECT_SIZE));
  assign mid_calc  = lo + ((hi - lo) >> 1);

  // direct value memory
  always_ff @(posedge clk) begin
    if (direct_we) begin
      direct_mem[dir_idx] <= value_r;
    end
    direct_rdata <= direct_mem[dir_idx];
  end

  // sorted entry memory, one write and one read port
  always_ff @(posedge clk) begin
    if (sorted_we) begin
      sorted_mem[sorted_waddr] <= sorted_wdata;
    end
    sorted_rdata <= sorted_mem[sorted_raddr];
  end

  always_comb begin
    state_next   = state;
    lo_next      = lo;
    hi_next      = hi;
    mid_next     = mid;
    count_next   = count;
    j_next       = j;
    done_next    = 1'b0;
    found_next   = 1'b0;
    full_next    = 1'b0;
    fval_next    = '0;
    direct_we    = 1'b0;
    sorted_we    = 1'b0;
    sorted_waddr = mid[SORTED_AW-1:0];
    sorted_wdata = '{key: code_r, value: value_r};
    sorted_raddr = mid_calc[SORTED_AW-1:0];

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_DIR;
        end
      end
      ST_DIR: begin
        lo_next = '0;
        hi_next = count;
        if (!is_direct) begin
          state_next = ST_BS_ADDR;
        end else if (op_r == OP_INSERT) begin
          direct_we  = 1'b1;
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_DRD;
        end
      end
      ST_DRD: begin
        done_next  = 1'b1;
        found_next = direct_valid[dir_idx];
        fval_next  = direct_valid[dir_idx] ? direct_rdata : '0;
        state_next = ST_IDLE;
      end
      ST_BS_ADDR: begin
        if (lo < hi) begin
          mid_next   = mid_calc;
          state_next = ST_BS_CMP;
        end else if (op_r == OP_INSERT) begin
          state_next = ST_PLACE;
        end else begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_BS_CMP: begin
        priority if (sorted_rdata.key == code_r) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
          if (op_r == OP_INSERT) begin
            sorted_we = 1'b1;
          end else begin
            found_next = 1'b1;
            fval_next  = sorted_rdata.value;
          end
        end else if (sorted_rdata.key < code_r) begin
          lo_next    = mid + 1'b1;
          state_next = ST_BS_ADDR;
        end else begin
          hi_next    = mid;
          state_next = ST_BS_ADDR;
        end
      end
      ST_PLACE: begin
        // lo now holds the insert point
        if (count == CNT_W'(SORTED_CAP)) begin
          done_next  = 1'b1;
          full_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          j_next     = count;
          state_next = ST_SH_RD;
        end
      end
      ST_SH_RD: begin
        sorted_raddr = SORTED_AW'(j - 1'b1);
        if (j > lo) begin
          state_next = ST_SH_WR;
        end else begin
          sorted_we    = 1'b1;
          sorted_waddr = lo[SORTED_AW-1:0];
          count_next   = count + 1'b1;
          done_next    = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_SH_WR: begin
        sorted_we    = 1'b1;
        sorted_waddr = j[SORTED_AW-1:0];
        sorted_wdata = sorted_rdata;
        j_next       = j - 1'b1;
        state_next   = ST_SH_RD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      direct_valid <= '0;
      done         <= 1'b0;
      found        <= 1'b0;
      table_full   <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      done       <= done_next;
      found      <= found_next;
      table_full <= full_next;
      if (direct_we) begin
        direct_valid[dir_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= op;
      code_r  <= char_code;
      value_r <= entry_value;
    end
    lo          <= lo_next;
    hi          <= hi_next;
    mid         <= mid_next;
    j           <= j_next;
    found_value <= fval_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(SORTED_CAP))
    else $error("sorted count above capacity");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    table_full |-> (done && !found && found_value == '0))
    else $error("full flag on a result that is not a dropped insert");

  a_probe_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BS_CMP) |-> (mid < hi && mid >= lo && hi <= count))
    else $error("search probe outside the used entries");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not raised after a transfer");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the direct plus sorted code map. Requests are
// queued up front, driven in random bursts, and every done strobe is checked
// against a map predicted from the requests taken. The sorted table is grown
// randomly, then with a run of ascending keys near the top, and a smallest
// key is inserted after that run so the whole table shifts up.
// ----------------------------------------------------------------------------
module tb;
  import dpscm_pkg::*;

  localparam int STALL_LIMIT = 10000;
  localparam int TAIL_CYCLES = 50;
  localparam int RANDOM_ITEMS = 350;
  localparam int FILL_ITEMS = 100;
  localparam int LATE_ITEMS = 100;

  typedef struct {
    logic               op;
    logic [CODE_W-1:0]  code;
    logic [VALUE_W-1:0] value;
    bit                 drain;
  } code_req_t;

  typedef struct packed {
    logic               found;
    logic [VALUE_W-1:0] value;
    logic               table_full;
  } map_reply_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               op = OP_LOOKUP;
  logic [CODE_W-1:0]  char_code = '0;
  logic [VALUE_W-1:0] entry_value = '0;
  logic               busy;
  logic               done;
  logic               found;
  logic [VALUE_W-1:0] found_value;
  logic               table_full;

  // requests still to send, and replies owed for requests already taken
  code_req_t  code_requests[$];
  map_reply_t map_replies_due[$];
  code_req_t  cur_req;

  // predicted map contents
  bit                 direct_mark[DIRECT_SIZE];
  logic [VALUE_W-1:0] direct_val[DIRECT_SIZE];
  logic [VALUE_W-1:0] sorted_map[int];

  // sorted keys as they will stand once queued requests are taken
  bit planned_sorted[int];
  int planned_keys[$];

  int requests_taken = 0;
  int replies_seen = 0;
  int mismatches = 0;
  int stall_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int lookups = 0;
  int hits = 0;
  int stores = 0;
  int drops = 0;

  direct_plus_sorted_code_map_unit dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .char_code   (char_code),
    .entry_value (entry_value),
    .done        (done),
    .found       (found),
    .found_value (found_value),
    .table_full  (table_full)
  );

  always #10 clk = ~clk;

  function automatic map_reply_t map_apply(code_req_t r);
    map_reply_t rep;
    rep = '0;
    if (r.op == OP_INSERT) begin
      if (r.code < DIRECT_SIZE) begin
        direct_mark[r.code[DIRECT_AW-1:0]] = 1'b1;
        direct_val[r.code[DIRECT_AW-1:0]] = r.value;
        stores++;
      end else if (sorted_map.exists(int'(r.code)) || sorted_map.num() < SORTED_CAP) begin
        sorted_map[int'(r.code)] = r.value;
        stores++;
      end else begin
        rep.table_full = 1'b1;
        drops++;
      end
    end else begin
      lookups++;
      if (r.code < DIRECT_SIZE) begin
        if (direct_mark[r.code[DIRECT_AW-1:0]]) begin
          rep.found = 1'b1;
          rep.value = direct_val[r.code[DIRECT_AW-1:0]];
        end
      end else if (sorted_map.exists(int'(r.code))) begin
        rep.found = 1'b1;
        rep.value = sorted_map[int'(r.code)];
      end
      if (rep.found) hits++;
    end
    return rep;
  endfunction

  function automatic void queue_request(logic o, int code, int value, bit drain);
    code_req_t r;
    r.op = o;
    r.code = CODE_W'(code);
    r.value = VALUE_W'(value);
    r.drain = drain;
    code_requests.push_back(r);
    if (o == OP_INSERT && code >= DIRECT_SIZE && !planned_sorted.exists(code) &&
        planned_sorted.num() < SORTED_CAP) begin
      planned_sorted[code] = 1'b1;
      planned_keys.push_back(code);
    end
  endfunction

  // mostly well-formed traffic: hits on stored keys, overwrites, fresh keys
  function automatic void queue_random_request(int key_top);
    int kind;
    int key;
    bit drain;
    kind = $urandom_range(0, 99);
    drain = ($urandom_range(0, 59) == 0);
    key = planned_keys.size() != 0 ?
          planned_keys[$urandom_range(0, planned_keys.size() - 1)] : DIRECT_SIZE + 1;
    if (kind < 15)
      queue_request(OP_INSERT, $urandom_range(0, DIRECT_SIZE - 1), $urandom_range(0, 'hFFFF),
                    drain);
    else if (kind < 30)
      queue_request(OP_LOOKUP, $urandom_range(0, DIRECT_SIZE - 1), $urandom_range(0, 'hFFFF),
                    drain);
    else if (kind < 55)
      queue_request(OP_INSERT, $urandom_range(DIRECT_SIZE + 1, key_top),
                    $urandom_range(0, 'hFFFF), drain);
    else if (kind < 65)
      queue_request(OP_INSERT, key, $urandom_range(0, 'hFFFF), drain);
    else if (kind < 85)
      queue_request(OP_LOOKUP, key, $urandom_range(0, 'hFFFF), drain);
    else
      queue_request(OP_LOOKUP, $urandom_range(0, 'h1FFFFF), $urandom_range(0, 'hFFFF), drain);
  endfunction

  initial begin
    int fill_code;
    int spare_key;
    bit first;

    // direct table extremes and overwrite
    queue_request(OP_LOOKUP, 0, 0, 1'b0);
    queue_request(OP_LOOKUP, DIRECT_SIZE - 1, 'hFFFF, 1'b0);
    queue_request(OP_LOOKUP, DIRECT_SIZE, 0, 1'b0);
    queue_request(OP_LOOKUP, 'h1FFFFF, 0, 1'b0);
    queue_request(OP_INSERT, 0, 'hFFFF, 1'b0);
    queue_request(OP_INSERT, DIRECT_SIZE - 1, 0, 1'b0);
    queue_request(OP_INSERT, 0, 'h1234, 1'b0);
    queue_request(OP_LOOKUP, 0, 0, 1'b0);
    queue_request(OP_LOOKUP, DIRECT_SIZE - 1, 0, 1'b0);
    // sorted table: ends, middle insert, overwrite of a present key
    queue_request(OP_INSERT, 'h1FFFFF, 'hFFFF, 1'b0);
    queue_request(OP_INSERT, DIRECT_SIZE + 1, 'h0001, 1'b0);
    queue_request(OP_INSERT, 'h100000, 'hA5A5, 1'b0);
    queue_request(OP_INSERT, 'h0FFFFF, 'h5A5A, 1'b0);
    queue_request(OP_INSERT, DIRECT_SIZE + 1, 'hBEEF, 1'b1);
    queue_request(OP_LOOKUP, DIRECT_SIZE + 1, 0, 1'b0);
    queue_request(OP_LOOKUP, 'h100000, 0, 1'b0);
    queue_request(OP_LOOKUP, 'h0FFFFF, 0, 1'b0);
    queue_request(OP_LOOKUP, 'h1FFFFF, 'hFFFF, 1'b0);
    queue_request(OP_LOOKUP, 'h100001, 0, 1'b0);
    queue_request(OP_LOOKUP, DIRECT_SIZE + 2, 0, 1'b0);
    queue_request(OP_INSERT, 1, 0, 1'b1);
    queue_request(OP_LOOKUP, 1, 0, 1'b0);

    // random growth, keeping the top codes free for an in-order run
    repeat (RANDOM_ITEMS) queue_random_request('h1FF7FF);

    // run of ascending keys that land near the top
    fill_code = 'h1FF800;
    first = 1'b1;
    repeat (FILL_ITEMS) begin
      while (planned_sorted.exists(fill_code)) fill_code++;
      queue_request(OP_INSERT, fill_code, $urandom_range(0, 'hFFFF), first);
      first = 1'b0;
      fill_code++;
    end
    // smallest sorted key after the run: the whole table moves up one place
    queue_request(OP_INSERT, DIRECT_SIZE, $urandom_range(0, 'hFFFF), 1'b1);
    spare_key = DIRECT_SIZE + 2;
    while (planned_sorted.exists(spare_key)) spare_key++;
    queue_request(OP_INSERT, spare_key, 'hFFFF, 1'b0);
    queue_request(OP_LOOKUP, spare_key, 0, 1'b0);
    queue_request(OP_LOOKUP, DIRECT_SIZE, 0, 1'b0);
    queue_request(OP_INSERT, DIRECT_SIZE, 'h0F0F, 1'b0);
    queue_request(OP_LOOKUP, DIRECT_SIZE, 0, 1'b0);
    queue_request(OP_LOOKUP, 'h1FF800, 0, 1'b0);

    // more random traffic over the whole code range
    repeat (LATE_ITEMS) queue_random_request('h1FFFFF);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (code_requests.size() != 0 || start || requests_taken != replies_seen);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (map_replies_due.size() != 0) begin
      $error("%0d results never arrived", map_replies_due.size());
      mismatches++;
    end

    $display("run covered %0d lookups (%0d hits), %0d stored inserts, %0d dropped inserts",
             lookups, hits, stores, drops);
    $display("sorted table reached %0d of %0d entries", sorted_map.num(), SORTED_CAP);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // sender: bursts of transfers with random gaps, holds off on drain marks
  always @(posedge clk) begin : drive_proc
    map_reply_t rep;
    logic       next_start;
    if (rst) begin
      start <= 1'b0;
      burst_left = $urandom_range(1, 30);
      gap_left = 0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        rep = map_apply(cur_req);
        map_replies_due.push_back(rep);
        requests_taken++;
        void'(code_requests.pop_front());
        next_start = 1'b0;
        burst_left--;
        if (burst_left <= 0) begin
          gap_left = $urandom_range(1, 8);
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                    : $urandom_range(1, 30);
        end
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (code_requests.size() != 0 &&
                     !(code_requests[0].drain && requests_taken != replies_seen)) begin
          cur_req = code_requests[0];
          op <= cur_req.op;
          char_code <= cur_req.code;
          entry_value <= cur_req.value;
          next_start = 1'b1;
        end
      end
      start <= next_start;
    end
  end

  // receiver: every done strobe must match the oldest owed reply
  always @(posedge clk) begin : check_proc
    map_reply_t want;
    if (!rst && done) begin
      replies_seen <= replies_seen + 1;
      if (map_replies_due.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        want = map_replies_due.pop_front();
        if (found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found);
          mismatches++;
        end
        if (found_value !== want.value) begin
          $error("found_value: expected 0x%04h, got 0x%04h", want.value, found_value);
          mismatches++;
        end
        if (table_full !== want.table_full) begin
          $error("table_full: expected %0d, got %0d", want.table_full, table_full);
          mismatches++;
        end
      end
    end
  end

  // cycles with neither a transfer nor a result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without progress", stall_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

// ===== filelist.f =====
rtl/dpscm_pkg.sv
rtl/direct_plus_sorted_code_map_unit.sv
dv/tb.sv
